/* rtl/core/multichannel_sample_ring_buffer_macros.svh */
// Assertion macros for the multichannel sample ring buffer.
// Included by the top level; simulation builds check, synthesis builds drop them.
`ifndef MULTICHANNEL_SAMPLE_RING_BUFFER_MACROS_SVH
`define MULTICHANNEL_SAMPLE_RING_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
// Check an expression or property at every clock edge outside reset.
`define MSRB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Check that cons holds in the cycle after ante.
`define MSRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define MSRB_ASSERT(label, clk, rst_n, prop)
`define MSRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/msrb_pkg.sv */
// Shared types and constants for the multichannel sample ring buffer.
// No dependencies; imported by the top level, controller and datapath.
`default_nettype none
package msrb_pkg;
	localparam int DEF_MAX_CHANNELS = 32;
	localparam int DEF_MAX_DEPTH    = 1024;

	localparam int CFG_W     = 17;
	localparam int STAMP_W   = 64;
	localparam int SAMPLE_W  = 16;
	localparam int FN_W      = 16;
	localparam int CH_IDX_W  = 6;
	localparam int AVAIL_W   = 16;

	localparam logic [0:0] REG_ACTIVE_CHANNELS = 1'd0;
	localparam logic [0:0] REG_DEPTH_IN_USE    = 1'd1;

	localparam int RST_DEPTH = 1024;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_READ    = 2'd1,
		MODE_CONSUME = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	// controller -> datapath
	typedef struct packed {
		logic take;  // input beat accepted this cycle
		logic emit;  // load next read result, fetch the one after unless last
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a result
		logic range_ok;  // read offset lies within held frames
		logic last_ch;   // channel in flight is the frame's last
	} sts_t;
endpackage
`default_nettype wire

/* rtl/core/multichannel_sample_ring_buffer.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    mode, stamp, sample_value, frame_number
// out      out_valid / out_ready  stamp_out, value_out, channel_index, last,
//                                 valid_res, overflow, available_count
// cfg      cfg_we (no wait)       cfg_index, cfg_data
//
// Write, consume, clear and out-of-range read items each leave their result
// in the output register the next cycle.
// An in-range read makes one RAM fetch per channel through the single sample
// read port, and yields one result per cycle while out_ready holds.
// Reset empties the ring at once; RAM contents are not cleared.
// A stalled output holds its result; input is taken only when the output
// register is free or being emptied in the same cycle.
// Depends on msrb_pkg, msrb_ctrl, msrb_datapath and the macros header.
`default_nettype none
`include "multichannel_sample_ring_buffer_macros.svh"
module multichannel_sample_ring_buffer import msrb_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_DEPTH    = DEF_MAX_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 mode,
	input  wire logic [STAMP_W-1:0]         stamp,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic [FN_W-1:0]            frame_number,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [STAMP_W-1:0]              stamp_out,
	output logic signed [SAMPLE_W-1:0]      value_out,
	output logic [CH_IDX_W-1:0]             channel_index,
	output logic                            last,
	output logic                            valid_res,
	output logic                            overflow,
	output logic [AVAIL_W-1:0]              available_count
);
	cmd_t cmd;
	sts_t sts;

	msrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	msrb_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_DEPTH    (MAX_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.mode            (mode),
		.stamp           (stamp),
		.sample_value    (sample_value),
		.frame_number    (frame_number),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.stamp_out       (stamp_out),
		.value_out       (value_out),
		.channel_index   (channel_index),
		.last            (last),
		.valid_res       (valid_res),
		.overflow        (overflow),
		.available_count (available_count),
		.sts             (sts)
	);

	`MSRB_ASSERT(a_take_emit_excl, clk, arst_n, !(cmd.take && cmd.emit))
	`MSRB_ASSERT(a_nonlast_is_read, clk, arst_n, !(out_valid && !last) || (valid_res && !overflow))
	`MSRB_ASSERT_NEXT(a_read_holds_input, clk, arst_n, cmd.emit && !sts.last_ch, !in_ready)
endmodule
`default_nettype wire

/* rtl/core/msrb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module msrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/msrb_ctrl.sv */
// Controller of the ring buffer: accepts items and steps through frame reads.
// Depends on msrb_pkg.
`default_nettype none
module msrb_ctrl import msrb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] mode,
	input  wire sts_t       sts,
	output logic            in_ready,
	output cmd_t            cmd
);
	typedef enum logic {ST_IDLE, ST_READ} state_t;
	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign cmd.take = in_valid && in_ready;
	assign cmd.emit = (state_q == ST_READ) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && (mode_t'(mode) == MODE_READ) && sts.range_ok) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cmd.emit && sts.last_ch) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/msrb_datapath.sv */
// Datapath of the ring buffer: pointers, configuration, sample and stamp RAMs,
// output register. Depends on msrb_pkg and msrb_ram.
`default_nettype none
module msrb_datapath import msrb_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_DEPTH    = DEF_MAX_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire cmd_t                       cmd,
	input  wire logic [1:0]                 mode,
	input  wire logic [STAMP_W-1:0]         stamp,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic [FN_W-1:0]            frame_number,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [STAMP_W-1:0]              stamp_out,
	output logic signed [SAMPLE_W-1:0]      value_out,
	output logic [CH_IDX_W-1:0]             channel_index,
	output logic                            last,
	output logic                            valid_res,
	output logic                            overflow,
	output logic [AVAIL_W-1:0]              available_count,
	output sts_t                            sts
);
	localparam int FW   = $clog2(MAX_DEPTH);
	localparam int DW   = FW + 1;
	localparam int CW   = $clog2(MAX_CHANNELS + 1);
	localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SDEP = MAX_DEPTH * (2 ** CHW);
	localparam int CMPW = FN_W + 1;
	localparam int DEPTH_RST = (MAX_DEPTH < RST_DEPTH) ? MAX_DEPTH : RST_DEPTH;

	logic [CW-1:0] ch_q;
	logic [DW-1:0] depth_q;
	logic [FW-1:0] wr_q, old_q, cnt_q, rd_frame_q;
	logic [CW-1:0] chan_q, rd_chan_q;

	logic [CW-1:0]   ch_new;
	logic [DW-1:0]   depth_new;
	logic [CW-1:0]   wr_c, wr_c_inc, rd_chan_inc;
	logic            commit, full, ovf_w;
	logic [DW-1:0]   wr_sum, old_sum, old_plus;
	logic [FW-1:0]   wr_nx, old_inc, old_adv, cnt_inc, n;
	logic [CMPW-1:0] fn_ext, cnt_ext;
	logic            range_ok, is_read, rd_re, out_load;
	logic [STAMP_W-1:0]  stamp_rd;
	logic [SAMPLE_W-1:0] sample_rd;
	logic [FW+CHW-1:0]   rd_addr;

	logic [STAMP_W-1:0]  nx_stamp;
	logic [SAMPLE_W-1:0] nx_value;
	logic [CH_IDX_W-1:0] nx_chidx;
	logic                nx_last, nx_vres, nx_ovf;
	logic [AVAIL_W-1:0]  nx_avail;

	logic                out_valid_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [SAMPLE_W-1:0] value_q;
	logic [CH_IDX_W-1:0] chidx_q;
	logic                last_q, vres_q, ovf_q;
	logic [AVAIL_W-1:0]  avail_q;

	// clamp register values into the supported range
	assign ch_new = (cfg_data[6:0] == 7'd0) ? CW'(1) :
		(cfg_data[6:0] > 7'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : CW'(cfg_data[6:0]);
	assign depth_new = (cfg_data < CFG_W'(2)) ? DW'(2) :
		(cfg_data > CFG_W'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(cfg_data);

	// write side
	assign wr_c     = (chan_q >= ch_q) ? '0 : chan_q;
	assign wr_c_inc = wr_c + CW'(1);
	assign commit   = wr_c_inc >= ch_q;
	assign wr_sum   = DW'(wr_q) + DW'(1);
	assign wr_nx    = (wr_sum == depth_q) ? '0 : wr_sum[FW-1:0];
	assign full     = (DW'(cnt_q) + DW'(1)) == depth_q;
	assign ovf_w    = commit && full;
	assign old_sum  = DW'(old_q) + DW'(1);
	assign old_inc  = (old_sum == depth_q) ? '0 : old_sum[FW-1:0];
	assign cnt_inc  = cnt_q + FW'(1);

	// read offset and consume count share one add and wrap
	assign fn_ext   = CMPW'(frame_number);
	assign cnt_ext  = CMPW'(cnt_q);
	assign range_ok = fn_ext < cnt_ext;
	assign n        = range_ok ? fn_ext[FW-1:0] : cnt_q;
	assign old_plus = DW'(old_q) + DW'(n);
	assign old_adv  = (old_plus >= depth_q) ? FW'(old_plus - depth_q) : old_plus[FW-1:0];

	assign is_read     = mode_t'(mode) == MODE_READ;
	assign rd_chan_inc = rd_chan_q + CW'(1);
	assign sts.last_ch = rd_chan_inc == ch_q;
	assign sts.range_ok = range_ok;
	assign sts.out_free = !out_valid_q || out_ready;

	assign rd_re   = (cmd.take && is_read && range_ok) || (cmd.emit && !sts.last_ch);
	assign rd_addr = cmd.emit ? {rd_frame_q, rd_chan_inc[CHW-1:0]} : {old_adv, CHW'(0)};

	msrb_ram #(.WIDTH(SAMPLE_W), .DEPTH(SDEP)) u_sample_ram (
		.clk   (clk),
		.we    (cmd.take && (mode_t'(mode) == MODE_WRITE)),
		.waddr ({wr_q, wr_c[CHW-1:0]}),
		.wdata (sample_value),
		.re    (rd_re),
		.raddr (rd_addr),
		.rdata (sample_rd)
	);

	msrb_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_DEPTH)) u_stamp_ram (
		.clk   (clk),
		.we    (cmd.take && (mode_t'(mode) == MODE_WRITE) && (wr_c == '0)),
		.waddr (wr_q),
		.wdata (stamp),
		.re    (cmd.take && is_read && range_ok),
		.raddr (old_adv),
		.rdata (stamp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= CW'(1);
			depth_q    <= DW'(DEPTH_RST);
			wr_q       <= '0;
			old_q      <= '0;
			cnt_q      <= '0;
			chan_q     <= '0;
			rd_frame_q <= '0;
			rd_chan_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ACTIVE_CHANNELS) begin
				ch_q <= ch_new;
			end else begin
				depth_q <= depth_new;
			end
			wr_q   <= '0;
			old_q  <= '0;
			cnt_q  <= '0;
			chan_q <= '0;
		end else if (cmd.take) begin
			unique case (mode_t'(mode))
				MODE_WRITE: begin
					if (commit) begin
						wr_q   <= wr_nx;
						chan_q <= '0;
						if (full) begin
							old_q <= old_inc;  // drop the oldest frame
						end else begin
							cnt_q <= cnt_inc;
						end
					end else begin
						chan_q <= wr_c_inc;
					end
				end
				MODE_READ: begin
					rd_frame_q <= old_adv;
					rd_chan_q  <= '0;
				end
				MODE_CONSUME: begin
					old_q <= old_adv;
					cnt_q <= cnt_q - n;
				end
				MODE_CLEAR: begin
					wr_q   <= '0;
					old_q  <= '0;
					cnt_q  <= '0;
					chan_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.emit && !sts.last_ch) begin
			rd_chan_q <= rd_chan_inc;
		end
	end

	always_comb begin
		nx_stamp = '0;
		nx_value = '0;
		nx_chidx = '0;
		nx_last  = 1'b1;
		nx_vres  = 1'b0;
		nx_ovf   = 1'b0;
		nx_avail = AVAIL_W'(cnt_q);
		if (cmd.emit) begin
			nx_stamp = stamp_rd;
			nx_value = sample_rd;
			nx_chidx = CH_IDX_W'(rd_chan_q);
			nx_last  = sts.last_ch;
			nx_vres  = 1'b1;
		end else begin
			unique case (mode_t'(mode))
				MODE_WRITE: begin
					nx_chidx = CH_IDX_W'(wr_c);
					nx_ovf   = ovf_w;
					if (commit && !full) begin
						nx_avail = AVAIL_W'(cnt_inc);
					end
				end
				MODE_READ:    nx_avail = AVAIL_W'(cnt_q);
				MODE_CONSUME: nx_avail = AVAIL_W'(cnt_q - n);
				MODE_CLEAR:   nx_avail = '0;
				default: ;
			endcase
		end
	end

	// in-range reads load their results later, one per channel
	assign out_load = cmd.emit || (cmd.take && !(is_read && range_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			stamp_q <= nx_stamp;
			value_q <= nx_value;
			chidx_q <= nx_chidx;
			last_q  <= nx_last;
			vres_q  <= nx_vres;
			ovf_q   <= nx_ovf;
			avail_q <= nx_avail;
		end
	end

	assign out_valid       = out_valid_q;
	assign stamp_out       = stamp_q;
	assign value_out       = value_q;
	assign channel_index   = chidx_q;
	assign last            = last_q;
	assign valid_res       = vres_q;
	assign overflow        = ovf_q;
	assign available_count = avail_q;
endmodule
`default_nettype wire
